// File: rtl/npb_pkg.sv
// ----------------------------------------------------------------------------
// npb_pkg: shared types and constants for the nearest boundary point unit
// Widths of the fixed-point datapath, state encodings and the request and
// result records passed between the top level and the edge evaluator.
// ----------------------------------------------------------------------------
package npb_pkg;

    localparam int CW     = 16;          // Q8.8 coordinate width
    localparam int DW     = CW + 1;      // coordinate difference width
    localparam int MW     = 18;          // multiplier operand width
    localparam int PW     = 2 * MW;      // multiplier product width
    localparam int NUMW   = 35;          // signed projection numerator
    localparam int DENW   = 34;          // unsigned squared edge length
    localparam int SPLIT  = 17;          // numerator split for partial products
    localparam int ACCW   = 49;          // |d| * num, dividend of the divider
    localparam int QW     = 16;          // quotient width
    localparam int QCW    = $clog2(QW);  // divider step counter
    localparam int DISTW  = 33;          // squared distance of a candidate
    localparam int BESTW  = 34;          // held best squared distance

    localparam logic [BESTW-1:0] BEST_INIT = {BESTW{1'b1}};

    typedef logic signed [CW-1:0] coord_t;

    typedef struct packed {
        coord_t ax;
        coord_t ay;
        coord_t bx;
        coord_t by;
        coord_t px;
        coord_t py;
    } edge_req_t;

    typedef struct packed {
        coord_t             nx;
        coord_t             ny;
        logic [DISTW-1:0]   sq_dist;
    } edge_res_t;

    typedef enum logic [2:0] {
        TS_IDLE,
        TS_EDGE1,
        TS_START2,
        TS_EDGE2,
        TS_EMIT
    } top_state_t;

    typedef enum logic [3:0] {
        ES_IDLE,
        ES_WXDX,
        ES_WYDY,
        ES_DXDX,
        ES_DYDY,
        ES_SUMDEN,
        ES_DECIDE,
        ES_PLO,
        ES_PHI,
        ES_PSUM,
        ES_DIVGO,
        ES_DIVWAIT,
        ES_DIST1,
        ES_DIST2,
        ES_DIST3,
        ES_DONE
    } edge_state_t;

endpackage

// File: rtl/npb_vertex_if.sv
// ----------------------------------------------------------------------------
// npb_vertex_if: vertex input channel
// Valid/ready channel carrying one polygon vertex, the query point and the
// last-vertex mark per item.
// ----------------------------------------------------------------------------
interface npb_vertex_if;
    import npb_pkg::*;

    logic   valid;
    logic   ready;
    coord_t vertex_x;
    coord_t vertex_y;
    coord_t query_x;
    coord_t query_y;
    logic   last_vertex;

    modport source (
        output valid, vertex_x, vertex_y, query_x, query_y, last_vertex,
        input  ready
    );

    modport sink (
        input  valid, vertex_x, vertex_y, query_x, query_y, last_vertex,
        output ready
    );

endinterface

// File: rtl/npb_result_if.sv
// ----------------------------------------------------------------------------
// npb_result_if: result output channel
// Valid/ready channel carrying the nearest boundary point and its squared
// distance, one item per polygon.
// ----------------------------------------------------------------------------
interface npb_result_if;
    import npb_pkg::*;

    logic             valid;
    logic             ready;
    coord_t           nearest_x;
    coord_t           nearest_y;
    logic [DISTW-1:0] distance_sq;

    modport source (
        output valid, nearest_x, nearest_y, distance_sq,
        input  ready
    );

    modport sink (
        input  valid, nearest_x, nearest_y, distance_sq,
        output ready
    );

endinterface

// File: rtl/npb_mul.sv
// ----------------------------------------------------------------------------
// npb_mul: shared signed multiplier
// One 18 x 18 signed multiplier with a registered product, time-shared by
// every product the edge evaluator needs.
// ----------------------------------------------------------------------------
module npb_mul (
    input  logic                           clk,
    input  logic signed [npb_pkg::MW-1:0]  a,
    input  logic signed [npb_pkg::MW-1:0]  b,
    output logic signed [npb_pkg::PW-1:0]  prod
);
    import npb_pkg::*;

    logic signed [PW-1:0] prod_reg;

    always_ff @(posedge clk)
    begin
        prod_reg <= a * b;
    end

    assign prod = prod_reg;

endmodule

// File: rtl/npb_div.sv
// ----------------------------------------------------------------------------
// npb_div: serial restoring divider
// Produces one quotient bit per cycle. The caller guarantees that the
// quotient fits QW bits, so the top of the dividend starts as the remainder.
// ----------------------------------------------------------------------------
module npb_div (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [npb_pkg::ACCW-1:0]    dividend,
    input  logic [npb_pkg::DENW-1:0]    divisor,
    output logic                        done,
    output logic [npb_pkg::QW-1:0]      quotient
);
    import npb_pkg::*;

    logic             busy_reg;
    logic             done_reg;
    logic [QCW-1:0]   cnt_reg;
    logic [DENW-1:0]  rem_reg;
    logic [DENW-1:0]  div_reg;
    logic [QW-1:0]    low_reg;
    logic [QW-1:0]    quo_reg;

    logic [DENW:0]    trial;
    logic [DENW+1:0]  diff;
    logic             take;
    logic [DENW-1:0]  rem_next;

    always_comb
    begin
        trial    = {rem_reg, low_reg[QW-1]};
        diff     = {1'b0, trial} - {2'b00, div_reg};
        take     = ~diff[DENW+1];
        rem_next = take ? diff[DENW-1:0] : trial[DENW-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= QCW'(QW - 1);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= {{(DENW - ACCW + QW){1'b0}}, dividend[ACCW-1:QW]};
            low_reg <= dividend[QW-1:0];
            div_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            low_reg <= {low_reg[QW-2:0], 1'b0};
            quo_reg <= {quo_reg[QW-2:0], take};
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// File: rtl/npb_edge.sv
// ----------------------------------------------------------------------------
// npb_edge: edge evaluator
// Sequencer that projects the query point onto one segment, clamps it to the
// end points and returns the candidate with its squared distance, using the
// shared multiplier and the serial divider.
// ----------------------------------------------------------------------------
module npb_edge (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  npb_pkg::edge_req_t  req,
    output logic                done,
    output npb_pkg::edge_res_t  res
);
    import npb_pkg::*;

    edge_state_t state_reg;
    edge_state_t state_next;

    edge_req_t              req_reg;
    logic signed [DW-1:0]   dx_reg;
    logic signed [DW-1:0]   dy_reg;
    logic signed [DW-1:0]   wx_reg;
    logic signed [DW-1:0]   wy_reg;
    logic signed [NUMW-1:0] num_reg;
    logic [DENW-1:0]        den_reg;
    logic [ACCW-1:0]        acc_reg;
    logic                   axis_reg;
    coord_t                 nx_reg;
    coord_t                 ny_reg;
    logic [DISTW-1:0]       dist_reg;

    logic signed [MW-1:0]   mul_a;
    logic signed [MW-1:0]   mul_b;
    logic signed [PW-1:0]   mul_prod;
    logic                   div_start;
    logic                   div_done;
    logic [QW-1:0]          div_q;

    logic                   num_le0;
    logic                   num_ge_den;
    logic signed [DW-1:0]   dsel;
    logic                   dneg;
    logic [DW-1:0]          dabs_full;
    logic [CW-1:0]          dabs;
    logic signed [DW-1:0]   ex;
    logic signed [DW-1:0]   ey;
    logic [DW-1:0]          step;
    logic [DW-1:0]          interp;

    npb_mul u_mul (
        .clk  (clk),
        .a    (mul_a),
        .b    (mul_b),
        .prod (mul_prod)
    );

    npb_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (acc_reg),
        .divisor  (den_reg),
        .done     (div_done),
        .quotient (div_q)
    );

    always_comb
    begin
        // A zero-length edge gives a zero numerator, so it lands on the start.
        num_le0    = num_reg[NUMW-1] | (num_reg == '0);
        num_ge_den = ~num_reg[NUMW-1] & (num_reg[DENW-1:0] >= den_reg);
        dsel       = axis_reg ? dy_reg : dx_reg;
        dneg       = dsel[DW-1];
        dabs_full  = dneg ? DW'(-dsel) : DW'(dsel);
        dabs       = dabs_full[CW-1:0];
        ex         = {req_reg.px[CW-1], req_reg.px} - {nx_reg[CW-1], nx_reg};
        ey         = {req_reg.py[CW-1], req_reg.py} - {ny_reg[CW-1], ny_reg};
        // Quotient is |d| * num / den, so the sign of d restores truncation to zero.
        step       = {1'b0, div_q};
        interp     = (axis_reg ? {req_reg.ay[CW-1], req_reg.ay}
                               : {req_reg.ax[CW-1], req_reg.ax})
                     + (dneg ? DW'(-step) : step);
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ES_IDLE:    if (start) state_next = ES_WXDX;
            ES_WXDX:    state_next = ES_WYDY;
            ES_WYDY:    state_next = ES_DXDX;
            ES_DXDX:    state_next = ES_DYDY;
            ES_DYDY:    state_next = ES_SUMDEN;
            ES_SUMDEN:  state_next = ES_DECIDE;
            ES_DECIDE:  state_next = (num_le0 || num_ge_den) ? ES_DIST1 : ES_PLO;
            ES_PLO:     state_next = ES_PHI;
            ES_PHI:     state_next = ES_PSUM;
            ES_PSUM:    state_next = ES_DIVGO;
            ES_DIVGO:   state_next = ES_DIVWAIT;
            ES_DIVWAIT:
            begin
                if (div_done)
                begin
                    state_next = axis_reg ? ES_DIST1 : ES_PLO;
                end
            end
            ES_DIST1:   state_next = ES_DIST2;
            ES_DIST2:   state_next = ES_DIST3;
            ES_DIST3:   state_next = ES_DONE;
            ES_DONE:    state_next = ES_IDLE;
            default:    state_next = ES_IDLE;
        endcase
    end

    always_comb
    begin
        mul_a     = '0;
        mul_b     = '0;
        div_start = 1'b0;
        done      = 1'b0;
        case (state_reg)
            ES_WXDX:
            begin
                mul_a = {wx_reg[DW-1], wx_reg};
                mul_b = {dx_reg[DW-1], dx_reg};
            end
            ES_WYDY:
            begin
                mul_a = {wy_reg[DW-1], wy_reg};
                mul_b = {dy_reg[DW-1], dy_reg};
            end
            ES_DXDX:
            begin
                mul_a = {dx_reg[DW-1], dx_reg};
                mul_b = {dx_reg[DW-1], dx_reg};
            end
            ES_DYDY:
            begin
                mul_a = {dy_reg[DW-1], dy_reg};
                mul_b = {dy_reg[DW-1], dy_reg};
            end
            ES_PLO:
            begin
                mul_a = {2'b00, dabs};
                mul_b = {1'b0, num_reg[SPLIT-1:0]};
            end
            ES_PHI:
            begin
                mul_a = {2'b00, dabs};
                mul_b = {2'b00, num_reg[SPLIT+CW-1:SPLIT]};
            end
            ES_DIST1:
            begin
                mul_a = {ex[DW-1], ex};
                mul_b = {ex[DW-1], ex};
            end
            ES_DIST2:
            begin
                mul_a = {ey[DW-1], ey};
                mul_b = {ey[DW-1], ey};
            end
            ES_DIVGO:   div_start = 1'b1;
            ES_DONE:    done = 1'b1;
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ES_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Each product is taken up in the state after the one that presented its operands.
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ES_IDLE:
            begin
                if (start)
                begin
                    req_reg <= req;
                    dx_reg  <= {req.bx[CW-1], req.bx} - {req.ax[CW-1], req.ax};
                    dy_reg  <= {req.by[CW-1], req.by} - {req.ay[CW-1], req.ay};
                    wx_reg  <= {req.px[CW-1], req.px} - {req.ax[CW-1], req.ax};
                    wy_reg  <= {req.py[CW-1], req.py} - {req.ay[CW-1], req.ay};
                end
            end
            ES_WYDY:    num_reg <= mul_prod[NUMW-1:0];
            ES_DXDX:    num_reg <= num_reg + mul_prod[NUMW-1:0];
            ES_DYDY:    den_reg <= mul_prod[DENW-1:0];
            ES_SUMDEN:  den_reg <= den_reg + mul_prod[DENW-1:0];
            ES_DECIDE:
            begin
                axis_reg <= 1'b0;
                if (num_le0)
                begin
                    nx_reg <= req_reg.ax;
                    ny_reg <= req_reg.ay;
                end
                else if (num_ge_den)
                begin
                    nx_reg <= req_reg.bx;
                    ny_reg <= req_reg.by;
                end
            end
            ES_PHI:     acc_reg <= {{(ACCW - SPLIT - CW){1'b0}}, mul_prod[SPLIT+CW-1:0]};
            ES_PSUM:    acc_reg <= acc_reg + {mul_prod[ACCW-SPLIT-1:0], {SPLIT{1'b0}}};
            ES_DIVWAIT:
            begin
                if (div_done)
                begin
                    if (axis_reg)
                    begin
                        ny_reg <= interp[CW-1:0];
                    end
                    else
                    begin
                        nx_reg   <= interp[CW-1:0];
                        axis_reg <= 1'b1;
                    end
                end
            end
            ES_DIST2:   dist_reg <= mul_prod[DISTW-1:0];
            ES_DIST3:   dist_reg <= dist_reg + mul_prod[DISTW-1:0];
            default:    dist_reg <= dist_reg;
        endcase
    end

    assign res.nx      = nx_reg;
    assign res.ny      = ny_reg;
    assign res.sq_dist = dist_reg;

endmodule

// File: rtl/nearest_point_on_polygon_boundary_unit.sv
// ----------------------------------------------------------------------------
// nearest_point_on_polygon_boundary_unit: nearest point on a polygon boundary
// Streams polygon vertices and reports the boundary point nearest the query.
// ----------------------------------------------------------------------------
// Vertices arrive one item at a time on the vertex channel, each with the
// query point and a last-vertex mark. Every vertex after the first closes an
// edge with the previous one; the last vertex also evaluates the closing edge
// back to the first. One result item per polygon leaves on the result channel.
// The edge evaluator is slower for an interpolated projection than for one
// clamped to an end point: every product goes through one shared
// multiplier, and each interpolated coordinate waits on the 16-step serial
// divider. A first vertex is taken without an edge, and a middle vertex
// holds ready low while its edge is evaluated. A later last vertex holds it
// low through its own edge and the closing edge, and its result item appears
// as ready returns; a one-vertex polygon evaluates only the closing edge.
// The result sits in an output register, so a stalled receiver only holds
// the block once the next polygon is complete. Ready is low while an edge is
// being evaluated. Reset clears the sequencers and awaits a first vertex.
// ----------------------------------------------------------------------------
module nearest_point_on_polygon_boundary_unit (
    input  logic        clk,
    input  logic        rst_n,
    npb_vertex_if.sink  vertex,
    npb_result_if.source result
);
    import npb_pkg::*;

    top_state_t state_reg;
    top_state_t state_next;

    logic             mid_reg;
    coord_t           first_x_reg;
    coord_t           first_y_reg;
    coord_t           prev_x_reg;
    coord_t           prev_y_reg;
    coord_t           vtx_x_reg;
    coord_t           vtx_y_reg;
    coord_t           qx_reg;
    coord_t           qy_reg;
    logic             last_reg;
    coord_t           best_x_reg;
    coord_t           best_y_reg;
    logic [BESTW-1:0] best_dist_reg;
    logic             out_valid_reg;
    coord_t           out_x_reg;
    coord_t           out_y_reg;
    logic [DISTW-1:0] out_dist_reg;

    logic      in_ready;
    logic      accept;
    logic      edge_start;
    logic      edge_done;
    logic      emit;
    logic      better;
    edge_req_t edge_req;
    edge_res_t edge_res;

    npb_edge u_edge (
        .clk   (clk),
        .rst_n (rst_n),
        .start (edge_start),
        .req   (edge_req),
        .done  (edge_done),
        .res   (edge_res)
    );

    always_comb
    begin
        in_ready   = (state_reg == TS_IDLE);
        accept     = vertex.valid & in_ready;
        edge_start = (accept & mid_reg) | (state_reg == TS_START2);
        emit       = (state_reg == TS_EMIT) & (~out_valid_reg | result.ready);
        // Only a strictly smaller distance replaces the held candidate.
        better     = ({1'b0, edge_res.sq_dist} < best_dist_reg);
        if (state_reg == TS_IDLE)
        begin
            edge_req.ax = prev_x_reg;
            edge_req.ay = prev_y_reg;
            edge_req.bx = vertex.vertex_x;
            edge_req.by = vertex.vertex_y;
            edge_req.px = vertex.query_x;
            edge_req.py = vertex.query_y;
        end
        else
        begin
            edge_req.ax = vtx_x_reg;
            edge_req.ay = vtx_y_reg;
            edge_req.bx = first_x_reg;
            edge_req.by = first_y_reg;
            edge_req.px = qx_reg;
            edge_req.py = qy_reg;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            TS_IDLE:
            begin
                if (accept)
                begin
                    if (mid_reg)
                    begin
                        state_next = TS_EDGE1;
                    end
                    else if (vertex.last_vertex)
                    begin
                        state_next = TS_START2;
                    end
                end
            end
            TS_EDGE1:
            begin
                if (edge_done)
                begin
                    state_next = last_reg ? TS_START2 : TS_IDLE;
                end
            end
            TS_START2:  state_next = TS_EDGE2;
            TS_EDGE2:   if (edge_done) state_next = TS_EMIT;
            TS_EMIT:    if (emit) state_next = TS_IDLE;
            default:    state_next = TS_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= TS_IDLE;
            mid_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
            best_dist_reg <= BEST_INIT;
        end
        else
        begin
            state_reg <= state_next;
            if (accept && !mid_reg)
            begin
                mid_reg       <= 1'b1;
                best_dist_reg <= BEST_INIT;
            end
            else if (edge_done && better)
            begin
                best_dist_reg <= {1'b0, edge_res.sq_dist};
            end
            else if (emit)
            begin
                mid_reg       <= 1'b0;
                best_dist_reg <= BEST_INIT;
            end

            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            prev_x_reg <= vertex.vertex_x;
            prev_y_reg <= vertex.vertex_y;
            vtx_x_reg  <= vertex.vertex_x;
            vtx_y_reg  <= vertex.vertex_y;
            qx_reg     <= vertex.query_x;
            qy_reg     <= vertex.query_y;
            last_reg   <= vertex.last_vertex;
            if (!mid_reg)
            begin
                first_x_reg <= vertex.vertex_x;
                first_y_reg <= vertex.vertex_y;
                best_x_reg  <= '0;
                best_y_reg  <= '0;
            end
        end
        else if (edge_done && better)
        begin
            best_x_reg <= edge_res.nx;
            best_y_reg <= edge_res.ny;
        end

        if (emit)
        begin
            out_x_reg    <= best_x_reg;
            out_y_reg    <= best_y_reg;
            out_dist_reg <= best_dist_reg[DISTW-1:0];
        end
    end

    assign vertex.ready       = in_ready;
    assign result.valid       = out_valid_reg;
    assign result.nearest_x   = out_x_reg;
    assign result.nearest_y   = out_y_reg;
    assign result.distance_sq = out_dist_reg;

endmodule

// File: rtl/npb_checker.sv
// ----------------------------------------------------------------------------
// npb_checker: port-level checks for the nearest boundary point unit
// Watches the vertex and result channels of the top level over time.
// ----------------------------------------------------------------------------
module npb_checker (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    input  logic                        in_ready,
    input  logic                        in_last,
    input  logic                        out_valid,
    input  logic                        out_ready,
    input  logic [npb_pkg::CW-1:0]      out_x,
    input  logic [npb_pkg::CW-1:0]      out_y,
    input  logic [npb_pkg::DISTW-1:0]   out_dist
);
    import npb_pkg::*;

    // A last vertex always costs at least the closing edge.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && in_last |=> !in_ready ##1 !in_ready ##1 !in_ready)
    else $error("vertex taken too soon after a last vertex");

    // A new result only follows a stretch of work with the input held off.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(!in_ready))
    else $error("result appeared without the edge sequencer running");

    // The result cannot be produced in the cycle after a last vertex.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && in_last |=> !$rose(out_valid))
    else $error("result appeared straight after a last vertex");

    // A stalled result item holds its value.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_x) && $stable(out_y)
                                    && $stable(out_dist))
    else $error("stalled result item changed");

endmodule

bind nearest_point_on_polygon_boundary_unit npb_checker u_npb_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (vertex.valid),
    .in_ready  (vertex.ready),
    .in_last   (vertex.last_vertex),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .out_x     (result.nearest_x),
    .out_y     (result.nearest_y),
    .out_dist  (result.distance_sq)
);
